// File: rtl/circular_deque_defines.svh
// Assertion macros used by the checker file of the deque.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circular_deque check failed");

// The consequent must hold in the cycle after the antecedent.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circular_deque check failed");

`endif

// File: rtl/cdq_pkg.sv
`timescale 1ns / 1ps
package cdq_pkg;

    localparam int unsigned DEPTH_DEF      = 16;
    localparam int unsigned DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_REAR  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SEL_ZERO = 2'd0,
        SEL_RAM  = 2'd1,
        SEL_ONES = 2'd2
    } t_out_sel;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RESP = 1'b1
    } t_state;

    typedef struct packed {
        logic exec;
        logic respond;
    } t_ctrl;

endpackage

// File: rtl/cdq_ram.sv
`timescale 1ns / 1ps
module cdq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/cdq_ctrl.sv
`timescale 1ns / 1ps
module cdq_ctrl import cdq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output logic  o_busy,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RESP;
                end
            end
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        o_busy = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ctrl.exec = i_start;
            end
            S_RESP: begin
                o_ctrl.respond = 1'b1;
                o_busy         = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/cdq_datapath.sv
`timescale 1ns / 1ps
module cdq_datapath import cdq_pkg::*; #(
    parameter int unsigned DEPTH      = DEPTH_DEF,
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_ctrl                        i_ctrl,
    input  logic [1:0]                   i_mode,
    input  logic signed [DATA_WIDTH-1:0] i_data_in,
    output logic signed [DATA_WIDTH-1:0] o_data_out,
    output logic [1:0]                   o_status,
    output logic                         o_is_full,
    output logic                         o_is_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_entry_count
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    t_status          r_status, n_status;
    t_out_sel         r_sel, n_sel;

    t_mode            w_mode;
    logic             w_full, w_empty, w_last;
    logic [IDX_W-1:0] w_head_dn, w_head_up, w_tail_dn, w_tail_up;

    logic                  w_we, w_re;
    logic [IDX_W-1:0]      w_waddr, w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;

    assign w_mode  = t_mode'(i_mode);
    assign w_full  = (r_count == FULL_CNT);
    assign w_empty = (r_count == '0);
    assign w_last  = (r_count == CNT_W'(1));

    assign w_head_dn = (r_head == '0)       ? LAST_IDX : r_head - 1'b1;
    assign w_head_up = (r_head == LAST_IDX) ? '0       : r_head + 1'b1;
    assign w_tail_dn = (r_tail == '0)       ? LAST_IDX : r_tail - 1'b1;
    assign w_tail_up = (r_tail == LAST_IDX) ? '0       : r_tail + 1'b1;

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = r_status;
        n_sel    = r_sel;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_re     = 1'b0;
        w_raddr  = r_head;
        if (i_ctrl.exec) begin
            if (w_mode inside {MODE_PUSH_FRONT, MODE_PUSH_REAR}) begin
                n_sel = SEL_ZERO;
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    n_count  = r_count + 1'b1;
                    w_we     = 1'b1;
                    if (w_empty) begin
                        // An empty deque restarts both ends at the first slot.
                        n_head  = '0;
                        n_tail  = '0;
                        w_waddr = '0;
                    end else if (w_mode == MODE_PUSH_FRONT) begin
                        n_head  = w_head_dn;
                        w_waddr = w_head_dn;
                    end else begin
                        n_tail  = w_tail_up;
                        w_waddr = w_tail_up;
                    end
                end
            end else begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                    n_sel    = SEL_ONES;
                end else begin
                    n_status = ST_OK;
                    n_sel    = SEL_RAM;
                    n_count  = r_count - 1'b1;
                    w_re     = 1'b1;
                    // Popping the only entry leaves both indices where they are.
                    if (w_mode == MODE_POP_FRONT) begin
                        w_raddr = r_head;
                        if (!w_last) begin
                            n_head = w_head_up;
                        end
                    end else begin
                        w_raddr = r_tail;
                        if (!w_last) begin
                            n_tail = w_tail_dn;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_sel    <= n_sel;
    end

    cdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_data_in),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        case (r_sel)
            SEL_ZERO: o_data_out = '0;
            SEL_RAM:  o_data_out = w_rdata;
            SEL_ONES: o_data_out = '1;
            default:  o_data_out = '0;
        endcase
    end

    assign o_status      = r_status;
    assign o_is_full     = (r_count == FULL_CNT);
    assign o_is_empty    = (r_count == '0);
    assign o_entry_count = r_count;

endmodule

// File: rtl/circular_deque.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// request   in         start, busy         i_mode, i_data_in
// result    out        o_strobe            o_data_out, o_status, o_is_full,
//                                          o_is_empty, o_entry_count
//
// A request is taken at a clock edge with start high and busy low.
// Its result shows in the next cycle, for one cycle, with o_strobe high.
// busy is high during that cycle, so the next request waits for the result;
// the read port of the slot RAM is registered.
// Reset clears both indices and the count; the slot RAM is not cleared.
// The receiver cannot stall the result.
module circular_deque import cdq_pkg::*; #(
    parameter int unsigned DEPTH      = DEPTH_DEF,
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_mode,
    input  logic signed [DATA_WIDTH-1:0] i_data_in,
    output logic                         o_strobe,
    output logic signed [DATA_WIDTH-1:0] o_data_out,
    output logic [1:0]                   o_status,
    output logic                         o_is_full,
    output logic                         o_is_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_entry_count
);

    t_ctrl w_ctrl;

    cdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_ctrl  (w_ctrl)
    );

    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_mode        (i_mode),
        .i_data_in     (i_data_in),
        .o_data_out    (o_data_out),
        .o_status      (o_status),
        .o_is_full     (o_is_full),
        .o_is_empty    (o_is_empty),
        .o_entry_count (o_entry_count)
    );

    assign o_strobe = w_ctrl.respond;

endmodule

// File: rtl/cdq_checker.sv
`timescale 1ns / 1ps
`include "circular_deque_defines.svh"
module cdq_checker import cdq_pkg::*; #(
    parameter int unsigned DEPTH      = DEPTH_DEF,
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_strobe,
    input logic signed [DATA_WIDTH-1:0] o_data_out,
    input logic [1:0]                   o_status,
    input logic                         o_is_full,
    input logic                         o_is_empty,
    input logic [$clog2(DEPTH+1)-1:0]   o_entry_count
);

    // Every accepted request answers in the following cycle, once.
    `CDQ_ASSERT_NEXT(a_answer, i_clk, i_rst_n, start && !busy, o_strobe)
    `CDQ_ASSERT_NEXT(a_single, i_clk, i_rst_n, o_strobe, !o_strobe)

    // Flags must agree with the reported count.
    `CDQ_ASSERT_NOW(a_flags, i_clk, i_rst_n, o_strobe, (o_is_empty == (o_entry_count == '0)) && (o_is_full == (o_entry_count == ($clog2(DEPTH+1))'(DEPTH))))

    // A refused pop reports all ones on an empty deque.
    `CDQ_ASSERT_NOW(a_empty_pop, i_clk, i_rst_n, o_strobe && (o_status == ST_EMPTY), (o_data_out == '1) && o_is_empty)

endmodule

bind circular_deque cdq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_cdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_data_out    (o_data_out),
    .o_status      (o_status),
    .o_is_full     (o_is_full),
    .o_is_empty    (o_is_empty),
    .o_entry_count (o_entry_count)
);
